FILE: sv/xy_pair_text_parser_assert.svh
// Assertion macros for the coordinate pair parser.
`ifndef XY_PAIR_TEXT_PARSER_ASSERT_SVH
`define XY_PAIR_TEXT_PARSER_ASSERT_SVH

`ifndef SYNTH
// Combinational check, sampled at every rising edge outside reset.
`define XYP_ASSERT_NOW(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("xy_pair_text_parser: check failed");
// Antecedent in this cycle implies consequent in the next.
`define XYP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xy_pair_text_parser: sequence check failed");
`else
`define XYP_ASSERT_NOW(lbl, clk, rst, expr)
`define XYP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: sv/xypp_pkg.sv
// Shared constants for the coordinate pair parser.
`default_nettype none

package xypp_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 32;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_RUN  = 2'd1;
  localparam logic [1:0] PHASE_DONE = 2'd2;

endpackage

`default_nettype wire

FILE: sv/xy_pair_text_parser.sv
// Coordinate pair text parser: one character per beat, one result per string.
//
//   channel   direction  handshake                    payload
//   char      in         char_valid / char_ready      char_byte[7:0]
//   result    out        result_valid / result_ready  x_value, y_value, pair_valid, overflow
//
// One character is taken every cycle unless a NUL waits on a full result register; a NUL beat reaches its
// result through the character register, then the result register.
// The per-character update is one multiply-by-ten shift-add and a compare against the limit.
// Only a NUL stalls on a full result register; other characters keep flowing under stall.
// Synchronous reset clears the parse state and both valid flags.
`default_nettype none

module xy_pair_text_parser #(
  parameter int VALUE_WIDTH = xypp_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           char_valid,
  output logic                          char_ready,
  input  wire  [7:0]                    char_byte,
  output logic                          result_valid,
  input  wire                           result_ready,
  output logic signed [VALUE_WIDTH-1:0] x_value,
  output logic signed [VALUE_WIDTH-1:0] y_value,
  output logic                          pair_valid,
  output logic                          overflow
);

  localparam int MAG_W = VALUE_WIDTH - 1;
  localparam int ACC_W = MAG_W + 4;
  localparam logic [ACC_W-1:0] MAG_LIMIT = {4'b0000, {MAG_W{1'b1}}};

  // character register
  logic       stage_valid;
  logic [7:0] stage_char;

  // parse state
  logic [MAG_W-1:0] x_mag, x_mag_next;
  logic [MAG_W-1:0] y_mag, y_mag_next;
  logic [1:0]       x_phase, x_phase_next;
  logic [1:0]       y_phase, y_phase_next;
  logic             sep_seen, sep_seen_next;
  logic             x_neg, x_neg_next;
  logic             y_neg, y_neg_next;
  logic             sat, sat_next;

  logic result_valid_next;
  logic stage_fire;
  logic stage_nul;
  logic is_digit;
  logic [3:0]       digit;
  logic [MAG_W-1:0] mag_sel;
  logic [ACC_W-1:0] acc_sum;
  logic             acc_sat;
  logic [MAG_W-1:0] acc_mag;
  logic [VALUE_WIDTH-1:0] x_ext, y_ext;

  assign stage_nul  = (stage_char == xypp_pkg::CHAR_NUL);
  assign stage_fire = stage_valid && (!stage_nul || !result_valid || result_ready);
  assign char_ready = !stage_valid || stage_fire;

  assign is_digit = (stage_char >= xypp_pkg::CHAR_ZERO) && (stage_char <= xypp_pkg::CHAR_NINE);
  assign digit    = 4'(stage_char - xypp_pkg::CHAR_ZERO);

  // mag*10 + d, saturating at the largest positive value
  assign mag_sel = sep_seen ? y_mag : x_mag;
  assign acc_sum = ({4'b0000, mag_sel} << 3) + ({4'b0000, mag_sel} << 1)
                 + {{(ACC_W-4){1'b0}}, digit};
  assign acc_sat = (acc_sum > MAG_LIMIT);
  assign acc_mag = acc_sat ? {MAG_W{1'b1}} : acc_sum[MAG_W-1:0];

  assign x_ext = {1'b0, x_mag};
  assign y_ext = {1'b0, y_mag};

  always_comb begin
    x_mag_next    = x_mag;
    y_mag_next    = y_mag;
    x_phase_next  = x_phase;
    y_phase_next  = y_phase;
    sep_seen_next = sep_seen;
    x_neg_next    = x_neg;
    y_neg_next    = y_neg;
    sat_next      = sat;
    if (stage_fire) begin
      if (stage_nul) begin
        x_mag_next    = '0;
        y_mag_next    = '0;
        x_phase_next  = xypp_pkg::PHASE_IDLE;
        y_phase_next  = xypp_pkg::PHASE_IDLE;
        sep_seen_next = 1'b0;
        x_neg_next    = 1'b0;
        y_neg_next    = 1'b0;
        sat_next      = 1'b0;
      end else if (is_digit) begin
        if (!sep_seen) begin
          if (x_phase == xypp_pkg::PHASE_IDLE || x_phase == xypp_pkg::PHASE_RUN) begin
            x_mag_next   = acc_mag;
            x_phase_next = xypp_pkg::PHASE_RUN;
            sat_next     = sat || acc_sat;
          end
        end else begin
          if (y_phase == xypp_pkg::PHASE_IDLE || y_phase == xypp_pkg::PHASE_RUN) begin
            y_mag_next   = acc_mag;
            y_phase_next = xypp_pkg::PHASE_RUN;
            sat_next     = sat || acc_sat;
          end
        end
      end else begin
        // any other character closes a running digit run
        if (x_phase == xypp_pkg::PHASE_RUN) x_phase_next = xypp_pkg::PHASE_DONE;
        if (y_phase == xypp_pkg::PHASE_RUN) y_phase_next = xypp_pkg::PHASE_DONE;
        case (stage_char)
          xypp_pkg::CHAR_HYPHEN: begin
            if (sep_seen) y_neg_next = 1'b1;
            else          x_neg_next = 1'b1;
          end
          xypp_pkg::CHAR_COMMA,
          xypp_pkg::CHAR_SPACE: sep_seen_next = 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (stage_fire && stage_nul) result_valid_next = 1'b1;
    else if (result_ready)       result_valid_next = 1'b0;
    else                         result_valid_next = result_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
      x_mag        <= '0;
      y_mag        <= '0;
      x_phase      <= xypp_pkg::PHASE_IDLE;
      y_phase      <= xypp_pkg::PHASE_IDLE;
      sep_seen     <= 1'b0;
      x_neg        <= 1'b0;
      y_neg        <= 1'b0;
      sat          <= 1'b0;
    end else begin
      if (char_ready) stage_valid <= char_valid;
      result_valid <= result_valid_next;
      x_mag        <= x_mag_next;
      y_mag        <= y_mag_next;
      x_phase      <= x_phase_next;
      y_phase      <= y_phase_next;
      sep_seen     <= sep_seen_next;
      x_neg        <= x_neg_next;
      y_neg        <= y_neg_next;
      sat          <= sat_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (char_ready && char_valid) stage_char <= char_byte;
    if (stage_fire && stage_nul) begin
      if (x_phase == xypp_pkg::PHASE_IDLE) x_value <= '0;
      else x_value <= x_neg ? -x_ext : x_ext;
      if (y_phase == xypp_pkg::PHASE_IDLE) y_value <= '0;
      else y_value <= y_neg ? -y_ext : y_ext;
      pair_valid <= (x_phase != xypp_pkg::PHASE_IDLE) || (y_phase != xypp_pkg::PHASE_IDLE);
      overflow   <= sat;
    end
  end

`include "xy_pair_text_parser_assert.svh"

  `XYP_ASSERT_NEXT(a_nul_gives_result, clk, rst, stage_fire && stage_nul, result_valid)
  `XYP_ASSERT_NEXT(a_nul_clears_state, clk, rst, stage_fire && stage_nul, (x_phase == xypp_pkg::PHASE_IDLE) && (y_phase == xypp_pkg::PHASE_IDLE) && !sep_seen && !sat)
  `XYP_ASSERT_NOW(a_empty_is_zero, clk, rst, !result_valid || pair_valid || ((x_value == '0) && (y_value == '0)))
  `XYP_ASSERT_NOW(a_overflow_has_digits, clk, rst, !result_valid || !overflow || pair_valid)

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Testbench for xy_pair_text_parser: directed and random character streams checked against a parse predictor.
`timescale 1ns / 100ps

module tb;

  localparam int W = xypp_pkg::VALUE_WIDTH_DEFAULT;
  localparam logic [63:0] MAG_LIMIT = (64'd1 << (W - 1)) - 64'd1;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;

  typedef struct {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic                valid;
    logic                ovf;
  } pair_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                char_valid = 1'b0;
  logic                char_ready;
  logic [7:0]          char_byte = 8'h00;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic signed [W-1:0] x_value;
  logic signed [W-1:0] y_value;
  logic                pair_valid;
  logic                overflow;

  xy_pair_text_parser #(.VALUE_WIDTH(W)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_byte    (char_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .x_value      (x_value),
    .y_value      (y_value),
    .pair_valid   (pair_valid),
    .overflow     (overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parse state of the predictor
  logic [63:0] x_mag = '0;
  logic [63:0] y_mag = '0;
  logic [1:0]  x_phase = xypp_pkg::PHASE_IDLE;
  logic [1:0]  y_phase = xypp_pkg::PHASE_IDLE;
  logic        sep_seen = 1'b0;
  logic        x_neg = 1'b0;
  logic        y_neg = 1'b0;
  logic        sat_seen = 1'b0;

  pair_result_t pair_expect_q[$];
  int           mismatch_count = 0;
  int           chars_sent = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           hold_req = 1'b0;
  bit           hold_ack = 1'b0;
  int           hold_len = 0;
  int           hold_left = 0;

  function automatic logic [63:0] add_digit(logic [63:0] m, logic [63:0] d);
    if (m > (MAG_LIMIT - d) / 64'd10) begin
      sat_seen = 1'b1;
      return MAG_LIMIT;
    end
    return m * 64'd10 + d;
  endfunction

  function automatic logic signed [W-1:0] apply_sign(logic [63:0] m, logic neg);
    logic [63:0] v;
    v = neg ? (64'd0 - m) : m;
    return v[W-1:0];
  endfunction

  function automatic void parse_char(logic [7:0] c);
    pair_result_t r;
    logic         xs;
    logic         ys;
    if (c == xypp_pkg::CHAR_NUL) begin
      xs = (x_phase != xypp_pkg::PHASE_IDLE);
      ys = (y_phase != xypp_pkg::PHASE_IDLE);
      r.x = xs ? apply_sign(x_mag, x_neg) : '0;
      r.y = ys ? apply_sign(y_mag, y_neg) : '0;
      r.valid = xs || ys;
      r.ovf = sat_seen;
      pair_expect_q.push_back(r);
      x_mag = '0;
      y_mag = '0;
      x_phase = xypp_pkg::PHASE_IDLE;
      y_phase = xypp_pkg::PHASE_IDLE;
      sep_seen = 1'b0;
      x_neg = 1'b0;
      y_neg = 1'b0;
      sat_seen = 1'b0;
    end else if (c >= xypp_pkg::CHAR_ZERO && c <= xypp_pkg::CHAR_NINE) begin
      if (!sep_seen) begin
        if (x_phase == xypp_pkg::PHASE_IDLE || x_phase == xypp_pkg::PHASE_RUN) begin
          x_mag = add_digit(x_mag, 64'(c - xypp_pkg::CHAR_ZERO));
          x_phase = xypp_pkg::PHASE_RUN;
        end
      end else if (y_phase == xypp_pkg::PHASE_IDLE || y_phase == xypp_pkg::PHASE_RUN) begin
        y_mag = add_digit(y_mag, 64'(c - xypp_pkg::CHAR_ZERO));
        y_phase = xypp_pkg::PHASE_RUN;
      end
    end else begin
      // any other byte closes a running digit run
      if (x_phase == xypp_pkg::PHASE_RUN) x_phase = xypp_pkg::PHASE_DONE;
      if (y_phase == xypp_pkg::PHASE_RUN) y_phase = xypp_pkg::PHASE_DONE;
      if (c == xypp_pkg::CHAR_HYPHEN) begin
        if (sep_seen) y_neg = 1'b1;
        else x_neg = 1'b1;
      end else if (c == xypp_pkg::CHAR_COMMA || c == xypp_pkg::CHAR_SPACE) begin
        sep_seen = 1'b1;
      end
    end
  endfunction

  // receiver: random ready, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= hold_len;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    pair_result_t e;
    if (!rst && result_valid && result_ready) begin
      if (pair_expect_q.size() == 0) begin
        $error("unexpected result beat: x %0d y %0d", x_value, y_value);
        mismatch_count++;
      end else begin
        e = pair_expect_q.pop_front();
        if (x_value !== e.x) begin
          $error("x_value: expected %0d, got %0d", e.x, x_value);
          mismatch_count++;
        end
        if (y_value !== e.y) begin
          $error("y_value: expected %0d, got %0d", e.y, y_value);
          mismatch_count++;
        end
        if (pair_valid !== e.valid) begin
          $error("pair_valid: expected %0b, got %0b", e.valid, pair_valid);
          mismatch_count++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow: expected %0b, got %0b", e.ovf, overflow);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_byte <= c;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    parse_char(c);
    chars_sent++;
  endtask

  // whole string followed by its terminator
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(xypp_pkg::CHAR_NUL);
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) begin
      // no leading zero on long runs so runs of eleven digits or more really overflow
      if (i == 0 && n > 8) send_char(xypp_pkg::CHAR_ZERO + 8'($urandom_range(9, 1)));
      else send_char(xypp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    end
  endtask

  function automatic int run_len();
    if ($urandom_range(9) == 0) return $urandom_range(12, 9);
    return $urandom_range(4, 1);
  endfunction

  task automatic send_random_pair();
    int kind;
    int n;
    logic [7:0] pick;
    kind = $urandom_range(99);
    if (kind < 75) begin
      if ($urandom_range(1)) send_char(CHAR_LPAREN);
      if ($urandom_range(3) == 0) send_char(xypp_pkg::CHAR_HYPHEN);
      if ($urandom_range(7) != 0) send_digits(run_len());
      case ($urandom_range(2))
        0: send_char(xypp_pkg::CHAR_COMMA);
        1: send_char(xypp_pkg::CHAR_SPACE);
        default: begin
          send_char(xypp_pkg::CHAR_COMMA);
          send_char(xypp_pkg::CHAR_SPACE);
        end
      endcase
      if ($urandom_range(3) == 0) send_char(xypp_pkg::CHAR_HYPHEN);
      if ($urandom_range(7) != 0) send_digits(run_len());
      if ($urandom_range(1)) send_char(CHAR_RPAREN);
    end else begin
      // broken sequences and raw noise
      n = $urandom_range(10, 1);
      for (int i = 0; i < n; i++) begin
        case ((kind < 90) ? $urandom_range(6) : 6)
          0: pick = xypp_pkg::CHAR_ZERO + 8'($urandom_range(9));
          1: pick = xypp_pkg::CHAR_HYPHEN;
          2: pick = xypp_pkg::CHAR_COMMA;
          3: pick = xypp_pkg::CHAR_SPACE;
          4: pick = CHAR_LPAREN;
          5: pick = CHAR_RPAREN;
          default: pick = 8'($urandom_range(255, 1));
        endcase
        send_char(pick);
      end
    end
    send_char(xypp_pkg::CHAR_NUL);
  endtask

  task automatic test_directed();
    send_idle_pct = 23;
    recv_idle_pct = 50;
    send_text("(4500,380)");
    send_text("4500 380");
    send_text("5");
    send_text(",72");
    send_text("");
    send_text("()");
    send_text("-12,-34");
    send_text("12-,5-");
    send_text("-,-");
    send_text("2147483647,0");
    send_text("2147483648,-99999999999");
    send_text("12a34,5");
    send_text("1,2,3");
    send_text("1 2 3");
    send_text("9)9, 4(4");
    // high-bit bytes are plain non-digits
    send_char(8'h37);
    send_char(8'hFF);
    send_char(8'h38);
    send_char(8'h80);
    send_char(xypp_pkg::CHAR_COMMA);
    send_char(8'h7F);
    send_char(8'h31);
    send_char(xypp_pkg::CHAR_NUL);
  endtask

  task automatic test_random_mix(input int s_idle, input int r_idle, input int budget);
    int stop_at;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    stop_at = chars_sent + budget;
    while (chars_sent < stop_at) send_random_pair();
  endtask

  // receiver stalls long while terminators keep coming: input must back up
  task automatic test_stall_fill();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 300;
    hold_req = !hold_req;
    for (int i = 0; i < 20; i++) begin
      send_digits($urandom_range(3, 1));
      send_char(xypp_pkg::CHAR_COMMA);
      send_char(xypp_pkg::CHAR_NUL);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix(23, 50, 230);
    test_random_mix(50, 23, 230);
    test_random_mix(0, 0, 230);
    test_stall_fill();
    char_valid <= 1'b0;
    while (pair_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
